// ===== hw/rtl/longest_decreasing_subsequence_macros.svh =====
// assertion macros for the longest decreasing subsequence checker
// expects clk and arst_n in the scope of each use
`ifndef LONGEST_DECREASING_SUBSEQUENCE_MACROS_SVH
`define LONGEST_DECREASING_SUBSEQUENCE_MACROS_SVH

// checked only while out of reset
`define LDS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LDS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lds_pkg.sv =====
// shared types and constants for the longest decreasing subsequence block
// no dependencies
package lds_pkg;

	localparam int HEIGHT_W  = 16;
	localparam int LONGEST_W = 8;
	localparam logic [LONGEST_W-1:0] LONGEST_SAT = 8'd255;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_EMIT
	} state_t;

	// sequencer to compare unit
	typedef struct packed {
		logic start;
		logic acc;
	} cmp_ctrl_t;

endpackage

// ===== hw/rtl/lds_mem.sv =====
// single port write, registered read memory for heights and chain lengths
// no dependencies
module lds_mem #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 24,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/lds_cmp.sv =====
// shared compare unit: holds the new height and its running chain length
// depends on lds_pkg
module lds_cmp #(
	parameter int SB = 16,
	parameter int CB = 8
) (
	input  logic              clk,
	input  lds_pkg::cmp_ctrl_t ctrl,
	input  logic [SB-1:0]     height_in,
	input  logic [SB-1:0]     rd_height,
	input  logic [CB-1:0]     rd_chain,
	output logic [SB-1:0]     height_q,
	output logic [CB-1:0]     len_q
);

	logic hit;

	// strictly higher earlier element whose chain extends past the current length
	assign hit = (rd_height > height_q) && (rd_chain >= len_q);

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			height_q <= height_in;
			len_q    <= CB'(1);
		end else if (ctrl.acc && hit) begin
			len_q <= rd_chain + CB'(1);
		end
	end

endmodule

// ===== hw/rtl/lds_seq.sv =====
// sequencer: accepts a transaction, scans stored entries, writes back, emits
// depends on lds_pkg
module lds_seq #(
	parameter int MAX_ITEMS = 128,
	localparam int CW = $clog2(MAX_ITEMS + 1),
	localparam int AW = $clog2(MAX_ITEMS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               last,
	input  logic               out_free,
	input  logic [CW-1:0]      len,
	output logic               item_stall,
	output lds_pkg::cmp_ctrl_t ctrl,
	output logic [AW-1:0]      raddr,
	output logic               we,
	output logic [AW-1:0]      waddr,
	output logic               emit,
	output logic [CW-1:0]      best,
	output logic               ovf
);

	lds_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] best_q, best_d;
	logic [CW-1:0] k_q, k_d;
	logic          ovf_q, ovf_d;
	logic          last_q, last_d;
	logic          rd_v_s1, rd_v_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lds_pkg::ST_IDLE;
			count_q <= '0;
			best_q  <= '0;
			k_q     <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
			rd_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			best_q  <= best_d;
			k_q     <= k_d;
			ovf_q   <= ovf_d;
			last_q  <= last_d;
			rd_v_s1 <= rd_v_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		best_d     = best_q;
		k_d        = k_q;
		ovf_d      = ovf_q;
		last_d     = last_q;
		rd_v_d     = 1'b0;
		item_stall = 1'b1;
		ctrl.start = 1'b0;
		ctrl.acc   = rd_v_s1;
		we         = 1'b0;
		emit       = 1'b0;
		unique case (state_q)
			lds_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					last_d = last;
					if (count_q == CW'(MAX_ITEMS)) begin
						ovf_d   = 1'b1;
						state_d = last ? lds_pkg::ST_EMIT : lds_pkg::ST_IDLE;
					end else begin
						ctrl.start = 1'b1;
						k_d        = '0;
						state_d    = (count_q == '0) ? lds_pkg::ST_WRITE : lds_pkg::ST_SCAN;
					end
				end
			end
			lds_pkg::ST_SCAN: begin
				rd_v_d = 1'b1;
				k_d    = k_q + CW'(1);
				if (k_d == count_q) begin
					state_d = lds_pkg::ST_DRAIN;
				end
			end
			lds_pkg::ST_DRAIN: begin
				state_d = lds_pkg::ST_WRITE;
			end
			lds_pkg::ST_WRITE: begin
				we      = 1'b1;
				count_d = count_q + CW'(1);
				if (len > best_q) begin
					best_d = len;
				end
				state_d = last_q ? lds_pkg::ST_EMIT : lds_pkg::ST_IDLE;
			end
			lds_pkg::ST_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					count_d = '0;
					best_d  = '0;
					ovf_d   = 1'b0;
					state_d = lds_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lds_pkg::ST_IDLE;
			end
		endcase
	end

	assign raddr = k_q[AW-1:0];
	assign waddr = count_q[AW-1:0];
	assign best  = best_q;
	assign ovf   = ovf_q;

endmodule

// ===== hw/rtl/longest_decreasing_subsequence.sv =====
// top level of the longest strictly decreasing subsequence block
// depends on lds_pkg, lds_mem, lds_cmp, lds_seq
//
//  channel   handshake                 payload
//  item      item_valid / item_stall   height[15:0], last
//  result    result_valid / result_stall longest[7:0], overflow
//
// an element with n stored before it passes the scan, drain and write states (n = 0: write only),
// the scan doing one read a cycle from the single read port of the element memory
// an element dropped because the store is full is taken in the idle state without a memory write
// a last element then passes the emit state to load the result register, held there while it is stalled
// reset clears the sequence count, best length, overflow flag and result valid
// the next transaction is accepted while a result waits behind result_stall
module longest_decreasing_subsequence #(
	parameter int MAX_ITEMS   = 128,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [lds_pkg::HEIGHT_W-1:0]    height,
	input  logic                            last,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [lds_pkg::LONGEST_W-1:0]   longest,
	output logic                            overflow
);

	localparam int SB = (HEIGHT_BITS < lds_pkg::HEIGHT_W) ? HEIGHT_BITS : lds_pkg::HEIGHT_W;
	localparam int CB = $clog2(MAX_ITEMS + 1);
	localparam int AW = $clog2(MAX_ITEMS);

	lds_pkg::cmp_ctrl_t ctrl;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic               we;
	logic [SB+CB-1:0]   rdata;
	logic [SB-1:0]      height_q;
	logic [CB-1:0]      len_q;
	logic               emit;
	logic [CB-1:0]      best;
	logic               ovf;
	logic               out_free;

	logic                          result_valid_q;
	logic [lds_pkg::LONGEST_W-1:0] longest_q;
	logic                          overflow_q;
	logic [lds_pkg::LONGEST_W-1:0] longest_sat;

	assign out_free = !result_valid_q || !result_stall;

	lds_seq #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.last      (last),
		.out_free  (out_free),
		.len       (len_q),
		.item_stall(item_stall),
		.ctrl      (ctrl),
		.raddr     (raddr),
		.we        (we),
		.waddr     (waddr),
		.emit      (emit),
		.best      (best),
		.ovf       (ovf)
	);

	lds_cmp #(
		.SB(SB),
		.CB(CB)
	) u_cmp (
		.clk      (clk),
		.ctrl     (ctrl),
		.height_in(height[SB-1:0]),
		.rd_height(rdata[SB+CB-1:CB]),
		.rd_chain (rdata[CB-1:0]),
		.height_q (height_q),
		.len_q    (len_q)
	);

	lds_mem #(
		.DEPTH(MAX_ITEMS),
		.WIDTH(SB + CB)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata({height_q, len_q}),
		.raddr(raddr),
		.rdata(rdata)
	);

	// saturate the chain length to the result width
	always_comb begin
		if (32'(best) > 32'(lds_pkg::LONGEST_SAT)) begin
			longest_sat = lds_pkg::LONGEST_SAT;
		end else begin
			longest_sat = lds_pkg::LONGEST_W'(best);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			longest_q  <= longest_sat;
			overflow_q <= ovf;
		end
	end

	assign result_valid = result_valid_q;
	assign longest      = longest_q;
	assign overflow     = overflow_q;

endmodule

// ===== hw/rtl/lds_checker.sv =====
// port level checks for the longest decreasing subsequence block
// depends on longest_decreasing_subsequence_macros.svh, bound to the top level
`include "longest_decreasing_subsequence_macros.svh"

module lds_checker #(
	parameter int MAX_ITEMS = 128
) (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_stall,
	input logic [7:0] longest,
	input logic       overflow
);

	localparam int LONGEST_MAX = (MAX_ITEMS < 255) ? MAX_ITEMS : 255;

	`LDS_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid, "result dropped while stalled")
	`LDS_ASSERT(a_result_stable, result_valid && result_stall |=> $stable(longest) && $stable(overflow), "result changed while stalled")
	`LDS_ASSERT(a_longest_nonzero, result_valid |-> longest != 8'd0, "zero length result")
	`LDS_ASSERT(a_longest_bound, result_valid |-> 32'(longest) <= 32'(LONGEST_MAX), "length beyond capacity")
	`LDS_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !result_valid, "result valid during reset")

endmodule

bind longest_decreasing_subsequence lds_checker #(.MAX_ITEMS(MAX_ITEMS)) u_lds_checker (.*);

// ===== test/longest_decreasing_subsequence_tb.sv =====
`timescale 1ns / 1ps
// testbench for longest_decreasing_subsequence: sends height sequences, predicts each chain length
// depends on lds_pkg and the longest_decreasing_subsequence rtl
module longest_decreasing_subsequence_tb;

	localparam int MAX_ITEMS    = 128;
	localparam int RANDOM_ITEMS = 520;
	localparam int IDLE_LIMIT   = 4000;
	localparam int TAIL_CYCLES  = 200;

	typedef logic [lds_pkg::HEIGHT_W-1:0] height_t;

	typedef struct {
		logic [lds_pkg::LONGEST_W-1:0] longest;
		logic                          overflow;
	} chain_result_t;

	class lds_chain_scoreboard;
		height_t       heights[MAX_ITEMS];
		int            chains[MAX_ITEMS];
		int            stored = 0;
		int            best = 0;
		logic          dropped = 1'b0;
		chain_result_t pending[$];
		int            mismatches = 0;

		task report_mismatch(string what, int expected, int got);
			$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, expected, got);
			mismatches++;
		endtask

		function void take_height(height_t h, logic is_last);
			chain_result_t r;
			int len;
			if (stored >= MAX_ITEMS) begin
				dropped = 1'b1;
			end else begin
				len = 1;
				for (int k = 0; k < stored; k++) begin
					if (heights[k] > h && chains[k] + 1 > len) begin
						len = chains[k] + 1;
					end
				end
				heights[stored] = h;
				chains[stored] = len;
				stored++;
				if (len > best) begin
					best = len;
				end
			end
			if (is_last) begin
				r.longest = (best > 255) ? lds_pkg::LONGEST_SAT : lds_pkg::LONGEST_W'(best);
				r.overflow = dropped;
				pending.push_back(r);
				stored = 0;
				best = 0;
				dropped = 1'b0;
			end
		endfunction

		task check_length(logic [lds_pkg::LONGEST_W-1:0] longest, logic overflow);
			chain_result_t r;
			if (pending.size() == 0) begin
				report_mismatch("unexpected transaction, longest", -1, longest);
			end else begin
				r = pending.pop_front();
				if (longest !== r.longest) begin
					report_mismatch("longest", r.longest, longest);
				end
				if (overflow !== r.overflow) begin
					report_mismatch("overflow", r.overflow, overflow);
				end
			end
		endtask
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          item_valid;
	logic                          item_stall;
	height_t                       height;
	logic                          last;
	logic                          result_valid;
	logic                          result_stall;
	logic [lds_pkg::LONGEST_W-1:0] longest;
	logic                          overflow;

	lds_chain_scoreboard sb;
	height_t             heights_to_send[$];
	bit                  no_idle = 1'b0;
	int                  idle_cycles = 0;

	longest_decreasing_subsequence #(
		.MAX_ITEMS  (MAX_ITEMS),
		.HEIGHT_BITS(lds_pkg::HEIGHT_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.height      (height),
		.last        (last),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.longest     (longest),
		.overflow    (overflow)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic height_t pick_height(int mode);
		case (mode)
			0: begin
				return height_t'($urandom_range(0, 15));
			end
			1: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return '1;
					default: return height_t'($urandom);
				endcase
			end
			default: begin
				return height_t'($urandom);
			end
		endcase
	endfunction

	task automatic send_item(height_t h, logic is_last);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		height <= h;
		last <= is_last;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic send_run();
		for (int i = 0; i < heights_to_send.size(); i++) begin
			send_item(heights_to_send[i], i == heights_to_send.size() - 1);
		end
		heights_to_send.delete();
	endtask

	task automatic send_random_runs();
		int sent;
		int seq;
		int len;
		int mode;
		height_t h;
		sent = 0;
		seq = 0;
		while (sent < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			mode = $urandom_range(0, 2);
			case (seq)
				// full store of one long strictly decreasing chain
				2: begin
					h = '1;
					for (int i = 0; i < MAX_ITEMS; i++) begin
						heights_to_send.push_back(h);
						h = h - height_t'($urandom_range(1, 400));
					end
				end
				// the last element falls beyond the store
				9: begin
					for (int i = 0; i < MAX_ITEMS + 1; i++) begin
						heights_to_send.push_back(pick_height(mode));
					end
				end
				// several dropped elements
				17: begin
					len = MAX_ITEMS + $urandom_range(2, 6);
					for (int i = 0; i < len; i++) begin
						heights_to_send.push_back(pick_height(mode));
					end
				end
				default: begin
					len = $urandom_range(1, 12);
					for (int i = 0; i < len; i++) begin
						heights_to_send.push_back(pick_height(mode));
					end
				end
			endcase
			sent += heights_to_send.size();
			seq++;
			send_run();
		end
	endtask

	// result side back pressure
	initial begin
		int n;
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = idle_len();
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			sb.take_height(height, last);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_length(longest, overflow);
		end
	end

	always @(posedge clk) begin
		if (arst_n && ((item_valid && !item_stall) || (result_valid && !result_stall))) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		sb = new;
		arst_n = 1'b0;
		item_valid = 1'b0;
		height = '0;
		last = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single elements at both extremes
		heights_to_send = '{16'h0000};
		send_run();
		heights_to_send = '{16'hffff};
		send_run();
		// strictly decreasing
		heights_to_send = '{16'hffff, 16'h8000, 16'h1234, 16'h0001, 16'h0000};
		send_run();
		// equal heights never extend a chain
		heights_to_send = '{16'h0007, 16'h0007, 16'h0007};
		send_run();
		heights_to_send = '{16'h0000, 16'h0001, 16'h0002, 16'h0003};
		send_run();
		heights_to_send = '{16'h0005, 16'h0003, 16'h0005, 16'h0003,
			16'h0004, 16'h0002, 16'h0000, 16'hffff};
		send_run();
		heights_to_send = '{16'haaaa, 16'h5555};
		send_run();

		send_random_runs();
		item_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
